// File: hdl/block_cipher_round_transforms_macros.svh
// Assertion macros used by the checker of the round transform block.
`ifndef BLOCK_CIPHER_ROUND_TRANSFORMS_MACROS_SVH
`define BLOCK_CIPHER_ROUND_TRANSFORMS_MACROS_SVH
// Antecedent implies consequent in the same cycle.
`define KRT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Antecedent implies consequent in the next cycle.
`define KRT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: hdl/krt_pkg.sv
// Types, command codes, tables and field arithmetic for the round transforms.
package krt_pkg;

    localparam int NUM_CELLS = 16;

    localparam logic [2:0] CMD_S   = 3'd0;
    localparam logic [2:0] CMD_IS  = 3'd1;
    localparam logic [2:0] CMD_R   = 3'd2;
    localparam logic [2:0] CMD_L   = 3'd3;
    localparam logic [2:0] CMD_IR  = 3'd4;
    localparam logic [2:0] CMD_IL  = 3'd5;
    localparam logic [2:0] CMD_XOR = 3'd6;

    localparam logic [8:0] GF_POLY = 9'h1C3;

    // Byte k of a block is element k, byte 0 being the least significant.
    typedef logic [15:0][7:0] blk_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] cmd;
        blk_t       blk;
    } stage_t;

    localparam logic [7:0] LAM_COEF [16] = '{
        8'd1, 8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1,
        8'd251, 8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148
    };

    localparam logic [7:0] SBOX_FWD [256] = '{
        8'd252, 8'd238, 8'd221, 8'd17, 8'd207, 8'd110, 8'd49, 8'd22, 8'd251, 8'd196,
        8'd250, 8'd218, 8'd35, 8'd197, 8'd4, 8'd77, 8'd233, 8'd119, 8'd240, 8'd219,
        8'd147, 8'd46, 8'd153, 8'd186, 8'd23, 8'd54, 8'd241, 8'd187, 8'd20, 8'd205,
        8'd95, 8'd193, 8'd249, 8'd24, 8'd101, 8'd90, 8'd226, 8'd92, 8'd239, 8'd33,
        8'd129, 8'd28, 8'd60, 8'd66, 8'd139, 8'd1, 8'd142, 8'd79, 8'd5, 8'd132,
        8'd2, 8'd174, 8'd227, 8'd106, 8'd143, 8'd160, 8'd6, 8'd11, 8'd237, 8'd152,
        8'd127, 8'd212, 8'd211, 8'd31, 8'd235, 8'd52, 8'd44, 8'd81, 8'd234, 8'd200,
        8'd72, 8'd171, 8'd242, 8'd42, 8'd104, 8'd162, 8'd253, 8'd58, 8'd206, 8'd204,
        8'd181, 8'd112, 8'd14, 8'd86, 8'd8, 8'd12, 8'd118, 8'd18, 8'd191, 8'd114,
        8'd19, 8'd71, 8'd156, 8'd183, 8'd93, 8'd135, 8'd21, 8'd161, 8'd150, 8'd41,
        8'd16, 8'd123, 8'd154, 8'd199, 8'd243, 8'd145, 8'd120, 8'd111, 8'd157, 8'd158,
        8'd178, 8'd177, 8'd50, 8'd117, 8'd25, 8'd61, 8'd255, 8'd53, 8'd138, 8'd126,
        8'd109, 8'd84, 8'd198, 8'd128, 8'd195, 8'd189, 8'd13, 8'd87, 8'd223, 8'd245,
        8'd36, 8'd169, 8'd62, 8'd168, 8'd67, 8'd201, 8'd215, 8'd121, 8'd214, 8'd246,
        8'd124, 8'd34, 8'd185, 8'd3, 8'd224, 8'd15, 8'd236, 8'd222, 8'd122, 8'd148,
        8'd176, 8'd188, 8'd220, 8'd232, 8'd40, 8'd80, 8'd78, 8'd51, 8'd10, 8'd74,
        8'd167, 8'd151, 8'd96, 8'd115, 8'd30, 8'd0, 8'd98, 8'd68, 8'd26, 8'd184,
        8'd56, 8'd130, 8'd100, 8'd159, 8'd38, 8'd65, 8'd173, 8'd69, 8'd70, 8'd146,
        8'd39, 8'd94, 8'd85, 8'd47, 8'd140, 8'd163, 8'd165, 8'd125, 8'd105, 8'd213,
        8'd149, 8'd59, 8'd7, 8'd88, 8'd179, 8'd64, 8'd134, 8'd172, 8'd29, 8'd247,
        8'd48, 8'd55, 8'd107, 8'd228, 8'd136, 8'd217, 8'd231, 8'd137, 8'd225, 8'd27,
        8'd131, 8'd73, 8'd76, 8'd63, 8'd248, 8'd254, 8'd141, 8'd83, 8'd170, 8'd144,
        8'd202, 8'd216, 8'd133, 8'd97, 8'd32, 8'd113, 8'd103, 8'd164, 8'd45, 8'd43,
        8'd9, 8'd91, 8'd203, 8'd155, 8'd37, 8'd208, 8'd190, 8'd229, 8'd108, 8'd82,
        8'd89, 8'd166, 8'd116, 8'd210, 8'd230, 8'd244, 8'd180, 8'd192, 8'd209, 8'd102,
        8'd175, 8'd194, 8'd57, 8'd75, 8'd99, 8'd182
    };

    localparam logic [7:0] SBOX_INV [256] = '{
        8'ha5, 8'h2d, 8'h32, 8'h8f, 8'h0e, 8'h30, 8'h38, 8'hc0, 8'h54, 8'he6, 8'h9e, 8'h39,
        8'h55, 8'h7e, 8'h52, 8'h91, 8'h64, 8'h03, 8'h57, 8'h5a, 8'h1c, 8'h60, 8'h07, 8'h18,
        8'h21, 8'h72, 8'ha8, 8'hd1, 8'h29, 8'hc6, 8'ha4, 8'h3f, 8'he0, 8'h27, 8'h8d, 8'h0c,
        8'h82, 8'hea, 8'hae, 8'hb4, 8'h9a, 8'h63, 8'h49, 8'he5, 8'h42, 8'he4, 8'h15, 8'hb7,
        8'hc8, 8'h06, 8'h70, 8'h9d, 8'h41, 8'h75, 8'h19, 8'hc9, 8'haa, 8'hfc, 8'h4d, 8'hbf,
        8'h2a, 8'h73, 8'h84, 8'hd5, 8'hc3, 8'haf, 8'h2b, 8'h86, 8'ha7, 8'hb1, 8'hb2, 8'h5b,
        8'h46, 8'hd3, 8'h9f, 8'hfd, 8'hd4, 8'h0f, 8'h9c, 8'h2f, 8'h9b, 8'h43, 8'hef, 8'hd9,
        8'h79, 8'hb6, 8'h53, 8'h7f, 8'hc1, 8'hf0, 8'h23, 8'he7, 8'h25, 8'h5e, 8'hb5, 8'h1e,
        8'ha2, 8'hdf, 8'ha6, 8'hfe, 8'hac, 8'h22, 8'hf9, 8'he2, 8'h4a, 8'hbc, 8'h35, 8'hca,
        8'hee, 8'h78, 8'h05, 8'h6b, 8'h51, 8'he1, 8'h59, 8'ha3, 8'hf2, 8'h71, 8'h56, 8'h11,
        8'h6a, 8'h89, 8'h94, 8'h65, 8'h8c, 8'hbb, 8'h77, 8'h3c, 8'h7b, 8'h28, 8'hab, 8'hd2,
        8'h31, 8'hde, 8'hc4, 8'h5f, 8'hcc, 8'hcf, 8'h76, 8'h2c, 8'hb8, 8'hd8, 8'h2e, 8'h36,
        8'hdb, 8'h69, 8'hb3, 8'h14, 8'h95, 8'hbe, 8'h62, 8'ha1, 8'h3b, 8'h16, 8'h66, 8'he9,
        8'h5c, 8'h6c, 8'h6d, 8'had, 8'h37, 8'h61, 8'h4b, 8'hb9, 8'he3, 8'hba, 8'hf1, 8'ha0,
        8'h85, 8'h83, 8'hda, 8'h47, 8'hc5, 8'hb0, 8'h33, 8'hfa, 8'h96, 8'h6f, 8'h6e, 8'hc2,
        8'hf6, 8'h50, 8'hff, 8'h5d, 8'ha9, 8'h8e, 8'h17, 8'h1b, 8'h97, 8'h7d, 8'hec, 8'h58,
        8'hf7, 8'h1f, 8'hfb, 8'h7c, 8'h09, 8'h0d, 8'h7a, 8'h67, 8'h45, 8'h87, 8'hdc, 8'he8,
        8'h4f, 8'h1d, 8'h4e, 8'h04, 8'heb, 8'hf8, 8'hf3, 8'h3e, 8'h3d, 8'hbd, 8'h8a, 8'h88,
        8'hdd, 8'hcd, 8'h0b, 8'h13, 8'h98, 8'h02, 8'h93, 8'h80, 8'h90, 8'hd0, 8'h24, 8'h34,
        8'hcb, 8'hed, 8'hf4, 8'hce, 8'h99, 8'h10, 8'h44, 8'h40, 8'h92, 8'h3a, 8'h01, 8'h26,
        8'h12, 8'h1a, 8'h48, 8'h68, 8'hf5, 8'h81, 8'h8b, 8'hc7, 8'hd6, 8'h20, 8'h0a, 8'h08,
        8'h00, 8'h4c, 8'hd7, 8'h74
    };

    // Product in GF(2^8); with a constant operand this folds into an XOR network.
    function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
        logic [8:0] a;
        logic [7:0] acc;
        a   = {1'b0, x};
        acc = '0;
        for (int k = 0; k < 8; k++)
        begin
            if (y[k])
            begin
                acc = acc ^ a[7:0];
            end
            a = {a[7:0], 1'b0};
            if (a[8])
            begin
                a = a ^ GF_POLY;
            end
        end
        return acc;
    endfunction

    function automatic logic [7:0] lambda16(input blk_t v);
        logic [7:0] acc;
        acc = '0;
        for (int k = 0; k < 16; k++)
        begin
            acc = acc ^ gf_mul(LAM_COEF[k], v[k]);
        end
        return acc;
    endfunction

endpackage

// File: hdl/krt_prep.sv
// Entry stage: takes a transfer in and applies the byte substitutions or the XOR; other commands pass through.
module krt_prep
    import krt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  logic          in_valid,
    input  logic [2:0]    cmd,
    input  blk_t          blk_in,
    input  blk_t          key_in,
    output stage_t        stage_out
);

    logic   valid_reg;
    logic   [2:0] cmd_reg;
    blk_t   blk_reg;
    blk_t   blk_next;

    always_comb
    begin
        blk_next = blk_in;
        case (cmd)
            CMD_S:
            begin
                for (int k = 0; k < 16; k++)
                begin
                    blk_next[k] = SBOX_FWD[blk_in[k]];
                end
            end
            CMD_IS:
            begin
                for (int k = 0; k < 16; k++)
                begin
                    blk_next[k] = SBOX_INV[blk_in[k]];
                end
            end
            CMD_XOR:
            begin
                blk_next = blk_in ^ key_in;
            end
            default:
            begin
                blk_next = blk_in;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cmd_reg <= cmd;
            blk_reg <= blk_next;
        end
    end

    assign stage_out = '{valid: valid_reg, cmd: cmd_reg, blk: blk_reg};

endmodule

// File: hdl/krt_cell.sv
// One cell of the chain: an optional forward or inverse R step, then a register.
module krt_cell
    import krt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   advance,
    input  logic   lead,
    input  stage_t stage_in,
    output stage_t stage_out
);

    logic   valid_reg;
    logic   [2:0] cmd_reg;
    blk_t   blk_reg;
    blk_t   blk_next;
    blk_t   rot;
    logic   do_step;
    logic   fwd;

    // The full transforms step in every cell; a single step only in the lead cell.
    assign do_step = (stage_in.cmd == CMD_L) || (stage_in.cmd == CMD_IL) ||
                     (lead && ((stage_in.cmd == CMD_R) || (stage_in.cmd == CMD_IR)));
    assign fwd     = (stage_in.cmd == CMD_L) || (stage_in.cmd == CMD_R);

    always_comb
    begin
        rot    = stage_in.blk;
        rot[0] = stage_in.blk[15];
        for (int k = 1; k < 16; k++)
        begin
            rot[k] = stage_in.blk[k - 1];
        end
        blk_next = stage_in.blk;
        if (do_step && fwd)
        begin
            for (int k = 0; k < 15; k++)
            begin
                blk_next[k] = stage_in.blk[k + 1];
            end
            blk_next[15] = lambda16(stage_in.blk);
        end
        else if (do_step)
        begin
            blk_next    = rot;
            blk_next[0] = lambda16(rot);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cmd_reg <= stage_in.cmd;
            blk_reg <= blk_next;
        end
    end

    assign stage_out = '{valid: valid_reg, cmd: cmd_reg, blk: blk_reg};

endmodule

// File: hdl/block_cipher_round_transforms.sv
// Path from input transfer to result: entry stage plus 16 cells.
// Throughput: one block per cycle; the chain moves as a whole whenever the
// last cell is empty or its result is taken, so in_stall follows out_stall.
// The L transforms use all 16 cells, one R step in each.
// Reset clears every valid bit at once; data registers are not reset.
module block_cipher_round_transforms
    import krt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [63:0] data_hi,
    input  logic [63:0] data_lo,
    input  logic [63:0] key_hi,
    input  logic [63:0] key_lo,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] res_hi,
    output logic [63:0] res_lo
);

    stage_t stage [NUM_CELLS + 1];
    logic   advance;

    assign advance  = !stage[NUM_CELLS].valid || !out_stall;
    assign in_stall = !advance;

    krt_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (in_valid),
        .cmd       (cmd),
        .blk_in    ({data_hi, data_lo}),
        .key_in    ({key_hi, key_lo}),
        .stage_out (stage[0])
    );

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        krt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .lead      (i == 0),
            .stage_in  (stage[i]),
            .stage_out (stage[i + 1])
        );
    end

    assign out_valid = stage[NUM_CELLS].valid;
    assign res_hi    = stage[NUM_CELLS].blk[15:8];
    assign res_lo    = stage[NUM_CELLS].blk[7:0];

endmodule

// File: hdl/krt_check.sv
// Port-level checker for the round transform block and its bind.
`include "block_cipher_round_transforms_macros.svh"
module krt_check (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] res_hi,
    input logic [63:0] res_lo
);

    `KRT_ASSERT_NXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(res_hi) && $stable(res_lo), "stalled result changed")
    `KRT_ASSERT_NOW(a_in_stall_cause, in_stall, out_valid && out_stall,
        "input stalled without a stalled result")
    `KRT_ASSERT_NOW(a_in_flow, out_valid && !out_stall, !in_stall,
        "input stalled while result drains")
    `KRT_ASSERT_NOW(a_drop, $fell(out_valid), $past(!out_stall),
        "result dropped without transfer")

endmodule

bind block_cipher_round_transforms krt_check u_krt_check (.*);

// File: dv/tb.sv
// Self-checking testbench for the round transform block.
`timescale 1ns / 100ps

module tb;
    import krt_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  cmd;
    logic [63:0] data_hi;
    logic [63:0] data_lo;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] res_hi;
    logic [63:0] res_lo;

    int send_idle_pct;
    int recv_stall_pct;

    block_cipher_round_transforms dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .data_hi   (data_hi),
        .data_lo   (data_lo),
        .key_hi    (key_hi),
        .key_lo    (key_lo),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_hi    (res_hi),
        .res_lo    (res_lo)
    );

    // Expected blocks in order, worked out when the input transfer happens.
    class block_scoreboard;
        logic [127:0] pending_blocks[$];
        int           errors;

        function automatic logic [7:0] field_mul(logic [7:0] x, logic [7:0] y);
            logic [7:0] acc;
            logic [7:0] a;
            acc = 8'h00;
            a   = x;
            for (int k = 0; k < 8; k++)
            begin
                if (y[k])
                begin
                    acc ^= a;
                end
                a = a[7] ? ((a << 1) ^ GF_POLY[7:0]) : (a << 1);
            end
            return acc;
        endfunction

        function automatic logic [7:0] mix_byte(blk_t v);
            logic [7:0] acc;
            acc = 8'h00;
            for (int k = 0; k < 16; k++)
            begin
                acc ^= field_mul(LAM_COEF[k], v[k]);
            end
            return acc;
        endfunction

        function automatic blk_t shift_down(blk_t v);
            blk_t r;
            r = v >> 8;
            r[15] = mix_byte(v);
            return r;
        endfunction

        function automatic blk_t shift_up(blk_t v);
            blk_t r;
            r = {v[14:0], v[15]};
            r[0] = mix_byte(r);
            return r;
        endfunction

        function automatic logic [127:0] transform(logic [2:0] c, logic [127:0] d,
                                                   logic [127:0] k);
            blk_t v;
            v = d;
            case (c)
                CMD_S:   for (int i = 0; i < 16; i++) v[i] = SBOX_FWD[v[i]];
                CMD_IS:  for (int i = 0; i < 16; i++) v[i] = SBOX_INV[v[i]];
                CMD_R:   v = shift_down(v);
                CMD_L:   for (int i = 0; i < 16; i++) v = shift_down(v);
                CMD_IR:  v = shift_up(v);
                CMD_IL:  for (int i = 0; i < 16; i++) v = shift_up(v);
                CMD_XOR: v = d ^ k;
                default: v = d;
            endcase
            return v;
        endfunction

        function void note_input(logic [2:0] c, logic [127:0] d, logic [127:0] k);
            pending_blocks.push_back(transform(c, d, k));
        endfunction

        function void check_result(logic [63:0] hi, logic [63:0] lo);
            logic [127:0] want;
            if (pending_blocks.size() == 0)
            begin
                $display("%0t: unexpected result %h %h", $realtime, hi, lo);
                errors++;
                return;
            end
            want = pending_blocks.pop_front();
            if (hi !== want[127:64])
            begin
                $display("%0t: res_hi expected %h actual %h", $realtime, want[127:64], hi);
                errors++;
            end
            if (lo !== want[63:0])
            begin
                $display("%0t: res_lo expected %h actual %h", $realtime, want[63:0], lo);
                errors++;
            end
        endfunction
    endclass

    block_scoreboard board;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            board.note_input(cmd, {data_hi, data_lo}, {key_hi, key_lo});
        end
        if (rst_n && out_valid && !out_stall)
        begin
            board.check_result(res_hi, res_lo);
        end
    end

    // The receiver stalls at random; it never looks at valid.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic logic [63:0] rand_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(7))
            0: w = '0;
            1: w = '1;
            default: ;
        endcase
        return w;
    endfunction

    task automatic send_block(logic [2:0] c, logic [63:0] dh, logic [63:0] dl,
                              logic [63:0] kh, logic [63:0] kl);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        data_hi  <= dh;
        data_lo  <= dl;
        key_hi   <= kh;
        key_lo   <= kl;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_random(int count);
        for (int n = 0; n < count; n++)
        begin
            send_block(3'($urandom_range(7)), rand_word(), rand_word(),
                       rand_word(), rand_word());
        end
    endtask

    initial
    begin
        #400000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int waited;
        board          = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        out_stall      = 1'b0;
        cmd            = CMD_S;
        data_hi        = '0;
        data_lo        = '0;
        key_hi         = '0;
        key_lo         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every command, including the unused one, on extreme blocks.
        for (int c = 0; c < 8; c++)
        begin
            send_block(3'(c), '0, '0, '1, '1);
            send_block(3'(c), '1, '1, 64'h0123456789abcdef, 64'hfedcba9876543210);
        end
        send_block(CMD_XOR, 64'h8000000000000001, 64'h00000000000000ff, '1, '0);
        send_block(CMD_L, 64'h0, 64'h1, '0, '0);
        send_block(CMD_IL, 64'h8000000000000000, 64'h0, '0, '0);
        send_block(CMD_S, 64'h0f0e0d0c0b0a0908, 64'h0706050403020100, '0, '0);

        send_random(350);
        send_idle_pct = 72;
        send_random(330);
        send_idle_pct  = 0;
        recv_stall_pct = 72;
        send_random(330);
        send_idle_pct  = 32;
        recv_stall_pct = 32;
        send_random(320);
        in_valid <= 1'b0;

        waited = 0;
        while (board.pending_blocks.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);
        if (board.errors == 0 && board.pending_blocks.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
